// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property holds at every edge outside reset
`define SLE_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define SLE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define SLE_ASSERT(label, clk, rst, prop)
`define SLE_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== src/sle_pkg.sv =====
package sle_pkg;

   localparam int unsigned VALUE_W = 32;
   localparam int unsigned CAP_W = 5;
   localparam int unsigned CAP_RESET = 16;

   typedef enum logic [3:0] {
      REQ_APPEND       = 4'd0,
      REQ_INSERT       = 4'd1,
      REQ_UPDATE       = 4'd2,
      REQ_REMOVE_AT    = 4'd3,
      REQ_REMOVE_VALUE = 4'd4,
      REQ_FIND         = 4'd5,
      REQ_READ         = 4'd6,
      REQ_COUNT        = 4'd7,
      REQ_CLEAR        = 4'd8
   } req_code_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_WRITE,
      CELL_INSERT,
      CELL_DROP
   } cell_cmd_type;

   typedef struct packed {
      cell_cmd_type       cmd;
      logic [VALUE_W-1:0] value;
   } cell_ctrl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EXEC
   } state_type;

endpackage

// ===== src/sle_cell.sv =====
module sle_cell #(
   parameter int unsigned LIST_DEPTH = 16,
   parameter int unsigned CELL_INDEX = 0
) (
   input  logic                                clock,
   input  sle_pkg::cell_ctrl_type              ctrl,
   input  logic [$clog2(LIST_DEPTH)-1:0]       ctrl_pos,
   input  logic [$clog2(LIST_DEPTH+1)-1:0]     list_count,
   input  logic [sle_pkg::VALUE_W-1:0]         left_entry,
   input  logic [sle_pkg::VALUE_W-1:0]         right_entry,
   output logic [sle_pkg::VALUE_W-1:0]         entry,
   input  logic                                scan_found_prev,
   input  logic [$clog2(LIST_DEPTH)-1:0]       scan_pos_prev,
   input  logic [$clog2(LIST_DEPTH+1)-1:0]     scan_count_prev,
   output logic                                scan_found,
   output logic [$clog2(LIST_DEPTH)-1:0]       scan_pos,
   output logic [$clog2(LIST_DEPTH+1)-1:0]     scan_count
);

   localparam int unsigned IDX_W = $clog2(LIST_DEPTH);
   localparam int unsigned CNT_W = $clog2(LIST_DEPTH+1);
   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);
   localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(CELL_INDEX);

   logic [sle_pkg::VALUE_W-1:0] entry_ff, entry_in;
   logic                        scan_found_ff, scan_found_in;
   logic [IDX_W-1:0]            scan_pos_ff, scan_pos_in;
   logic [CNT_W-1:0]            scan_count_ff, scan_count_in;
   logic                        match;

   always_comb begin
      entry_in = entry_ff;
      case (ctrl.cmd)
         sle_pkg::CELL_WRITE: begin
            if (MY_IDX == ctrl_pos) entry_in = ctrl.value;
         end
         sle_pkg::CELL_INSERT: begin
            if (MY_IDX == ctrl_pos) entry_in = ctrl.value;
            else if (MY_IDX > ctrl_pos) entry_in = left_entry;
         end
         sle_pkg::CELL_DROP: begin
            if (MY_IDX >= ctrl_pos) entry_in = right_entry;
         end
         default: entry_in = entry_ff;
      endcase
   end

   // scan wave: first match and running count move one cell per cycle
   always_comb begin
      match         = (MY_CNT < list_count) && (entry_ff == ctrl.value);
      scan_found_in = scan_found_prev | match;
      scan_pos_in   = scan_found_prev ? scan_pos_prev : MY_IDX;
      scan_count_in = scan_count_prev + CNT_W'(match);
   end

   always_ff @(posedge clock) begin
      entry_ff      <= entry_in;
      scan_found_ff <= scan_found_in;
      scan_pos_ff   <= scan_pos_in;
      scan_count_ff <= scan_count_in;
   end

   assign entry      = entry_ff;
   assign scan_found = scan_found_ff;
   assign scan_pos   = scan_pos_ff;
   assign scan_count = scan_count_ff;

endmodule

// ===== src/sequential_list_engine_unit.sv =====
// sequence: a request is accepted in ST_IDLE; append, insert, update, remove at, read
// and clear go straight to ST_EXEC, remove value, find and count first pass ST_SCAN,
// where the match wave crosses the cell chain one cell per cycle; ST_EXEC registers the
// response once the response slot is free, and only then is a new request accepted
// reset: synchronous, clears list size, sets capacity to 16, entries stay as they are
`include "assert_macros.svh"

module sequential_list_engine_unit #(
   parameter int unsigned LIST_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // position[3:0], value[35:4]
   input  logic [3:0]  req_tuser,   // req_type[3:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // ok[0], read_value[32:1], found_position[36:33],
                                    // match_count[41:37], list_size[46:42]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [4:0]  csr_data     // capacity_limit[4:0]
);

   localparam int unsigned IDX_W = $clog2(LIST_DEPTH);
   localparam int unsigned CNT_W = $clog2(LIST_DEPTH+1);
   localparam int unsigned WIDE  = (CNT_W > sle_pkg::CAP_W) ? CNT_W : sle_pkg::CAP_W;

   sle_pkg::state_type          state_ff, state_in;
   logic [3:0]                  req_type_ff;
   logic [3:0]                  pos_ff;
   logic [sle_pkg::VALUE_W-1:0] value_ff;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic [sle_pkg::CAP_W-1:0]   capacity_ff;
   logic [IDX_W-1:0]            scan_cnt_ff;
   logic                        rsp_valid_ff;
   logic [47:0]                 rsp_data_ff;

   logic                        req_fire, fire, needs_scan, full, in_range;
   logic [WIDE-1:0]             pos_w, count_w, cap_w, fpos_w, mcnt_w, size_w;
   sle_pkg::cell_cmd_type       cmd;
   sle_pkg::cell_ctrl_type      ctrl;
   logic [IDX_W-1:0]            cpos;
   logic                        ok;
   logic [sle_pkg::VALUE_W-1:0] rd;
   logic [3:0]                  fp;
   logic [4:0]                  mc;

   logic [sle_pkg::VALUE_W-1:0] cell_entry [LIST_DEPTH];
   logic                        scan_found [LIST_DEPTH];
   logic [IDX_W-1:0]            scan_pos   [LIST_DEPTH];
   logic [CNT_W-1:0]            scan_count [LIST_DEPTH];

   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign needs_scan = (req_tuser == sle_pkg::REQ_REMOVE_VALUE) ||
                       (req_tuser == sle_pkg::REQ_FIND) ||
                       (req_tuser == sle_pkg::REQ_COUNT);

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      fire       = 1'b0;
      unique case (state_ff)
         sle_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) state_in = needs_scan ? sle_pkg::ST_SCAN : sle_pkg::ST_EXEC;
         end
         sle_pkg::ST_SCAN: begin
            if (scan_cnt_ff == IDX_W'(LIST_DEPTH - 1)) state_in = sle_pkg::ST_EXEC;
         end
         sle_pkg::ST_EXEC: begin
            fire = !rsp_valid_ff || rsp_tready;
            if (fire) state_in = sle_pkg::ST_IDLE;
         end
         default: state_in = sle_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      pos_w    = WIDE'(pos_ff);
      count_w  = WIDE'(count_ff);
      cap_w    = WIDE'(capacity_ff);
      fpos_w   = WIDE'(scan_pos[LIST_DEPTH-1]);
      mcnt_w   = WIDE'(scan_count[LIST_DEPTH-1]);
      full     = (count_ff == CNT_W'(LIST_DEPTH)) || (count_w >= cap_w);
      in_range = pos_w < count_w;
      cmd      = sle_pkg::CELL_HOLD;
      cpos     = pos_w[IDX_W-1:0];
      count_in = count_ff;
      ok       = 1'b0;
      rd       = '0;
      fp       = '0;
      mc       = '0;
      unique case (req_type_ff)
         sle_pkg::REQ_APPEND: begin
            if (!full) begin
               cmd      = sle_pkg::CELL_WRITE;
               cpos     = count_w[IDX_W-1:0];
               count_in = count_ff + 1'b1;
               ok       = 1'b1;
            end
         end
         sle_pkg::REQ_INSERT: begin
            if (!full && in_range) begin
               cmd      = sle_pkg::CELL_INSERT;
               count_in = count_ff + 1'b1;
               ok       = 1'b1;
            end
         end
         sle_pkg::REQ_UPDATE: begin
            if (in_range) begin
               cmd = sle_pkg::CELL_WRITE;
               ok  = 1'b1;
            end
         end
         sle_pkg::REQ_REMOVE_AT: begin
            if (in_range) begin
               cmd      = sle_pkg::CELL_DROP;
               count_in = count_ff - 1'b1;
               ok       = 1'b1;
            end
         end
         sle_pkg::REQ_REMOVE_VALUE: begin
            if (scan_found[LIST_DEPTH-1]) begin
               cmd      = sle_pkg::CELL_DROP;
               cpos     = scan_pos[LIST_DEPTH-1];
               count_in = count_ff - 1'b1;
               ok       = 1'b1;
            end
         end
         sle_pkg::REQ_FIND: begin
            if (scan_found[LIST_DEPTH-1]) begin
               fp = fpos_w[3:0];
               ok = 1'b1;
            end
         end
         sle_pkg::REQ_READ: begin
            if (in_range) begin
               rd = cell_entry[cpos];
               ok = 1'b1;
            end else begin
               rd = '1;
            end
         end
         sle_pkg::REQ_COUNT: begin
            mc = mcnt_w[4:0];
            ok = 1'b1;
         end
         sle_pkg::REQ_CLEAR: begin
            count_in = '0;
            ok       = 1'b1;
         end
         default: ok = 1'b0;
      endcase
      size_w     = WIDE'(count_in);
      ctrl.cmd   = fire ? cmd : sle_pkg::CELL_HOLD;
      ctrl.value = value_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sle_pkg::ST_IDLE;
         count_ff     <= '0;
         capacity_ff  <= sle_pkg::CAP_W'(sle_pkg::CAP_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) capacity_ff <= csr_data;
         if (fire) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         req_type_ff <= req_tuser;
         pos_ff      <= req_tdata[3:0];
         value_ff    <= req_tdata[35:4];
         scan_cnt_ff <= '0;
      end else if (state_ff == sle_pkg::ST_SCAN) begin
         scan_cnt_ff <= scan_cnt_ff + 1'b1;
      end
      if (fire) begin
         rsp_data_ff <= {1'b0, size_w[4:0], mc, fp, rd, ok};
      end
   end

   for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
      logic [sle_pkg::VALUE_W-1:0] left_entry, right_entry;
      logic                        found_prev;
      logic [IDX_W-1:0]            pos_prev;
      logic [CNT_W-1:0]            count_prev;

      if (g == 0) begin : g_head
         assign left_entry = cell_entry[g];
         assign found_prev = 1'b0;
         assign pos_prev   = '0;
         assign count_prev = '0;
      end else begin : g_body
         assign left_entry = cell_entry[g-1];
         assign found_prev = scan_found[g-1];
         assign pos_prev   = scan_pos[g-1];
         assign count_prev = scan_count[g-1];
      end

      if (g == LIST_DEPTH - 1) begin : g_tail
         assign right_entry = cell_entry[g];
      end else begin : g_inner
         assign right_entry = cell_entry[g+1];
      end

      sle_cell #(
         .LIST_DEPTH (LIST_DEPTH),
         .CELL_INDEX (g)
      ) u_cell (
         .clock           (clock),
         .ctrl            (ctrl),
         .ctrl_pos        (cpos),
         .list_count      (count_ff),
         .left_entry      (left_entry),
         .right_entry     (right_entry),
         .entry           (cell_entry[g]),
         .scan_found_prev (found_prev),
         .scan_pos_prev   (pos_prev),
         .scan_count_prev (count_prev),
         .scan_found      (scan_found[g]),
         .scan_pos        (scan_pos[g]),
         .scan_count      (scan_count[g])
      );
   end

   `SLE_ASSERT(a_size_bound, clock, reset, count_ff <= CNT_W'(LIST_DEPTH))
   `SLE_ASSERT_NEXT(a_scan_keeps_size, clock, reset, state_ff == sle_pkg::ST_SCAN, $stable(count_ff))
   `SLE_ASSERT(a_rsp_from_exec, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff == sle_pkg::ST_EXEC))
   `SLE_ASSERT_NEXT(a_exec_done, clock, reset, fire, rsp_valid_ff && state_ff == sle_pkg::ST_IDLE)

endmodule

// ===== bench/list_engine_checker.sv =====
module list_engine_checker #(
   parameter int unsigned LIST_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [39:0] req_tdata,   // position[3:0], value[35:4]
   input  logic [3:0]  req_tuser,   // req_type[3:0]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [47:0] rsp_tdata,   // ok[0], read_value[32:1], found_position[36:33],
                                    // match_count[41:37], list_size[46:42]
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [4:0]  csr_data,    // capacity_limit[4:0]
   output int          fail_count,
   output int          pending,
   output int          checked
);

   typedef struct packed {
      logic        ok;
      logic [31:0] read_value;
      logic [3:0]  found_position;
      logic [4:0]  match_count;
      logic [4:0]  list_size;
   } list_reply_type;

   logic [sle_pkg::VALUE_W-1:0] entries [LIST_DEPTH];
   int                          list_len = 0;
   logic [sle_pkg::CAP_W-1:0]   capacity = sle_pkg::CAP_W'(sle_pkg::CAP_RESET);
   list_reply_type              replies_due [$];
   int                          mismatches = 0;
   int                          replies_seen = 0;
   int                          outstanding = 0;

   assign fail_count = mismatches;
   assign pending    = outstanding;
   assign checked    = replies_seen;

   function automatic int first_hit(logic [31:0] v);
      int i;
      for (i = 0; i < list_len; i++) begin
         if (entries[i] == v) return i;
      end
      return -1;
   endfunction

   function automatic void drop_entry(int at);
      int i;
      for (i = at; i + 1 < list_len; i++) entries[i] = entries[i + 1];
      list_len--;
   endfunction

   function automatic list_reply_type apply_request(logic [3:0] code, logic [3:0] pos,
                                                    logic [31:0] val);
      list_reply_type r;
      int             room;
      int             hit;
      int             i;
      bit             full;
      r    = '0;
      room = (int'(capacity) < int'(LIST_DEPTH)) ? int'(capacity) : int'(LIST_DEPTH);
      full = list_len >= room;
      hit  = first_hit(val);
      case (code)
         sle_pkg::REQ_APPEND: begin
            if (!full) begin
               entries[list_len] = val;
               list_len++;
               r.ok = 1'b1;
            end
         end
         sle_pkg::REQ_INSERT: begin
            if (!full && int'(pos) < list_len) begin
               for (i = list_len; i > int'(pos); i--) entries[i] = entries[i - 1];
               entries[pos] = val;
               list_len++;
               r.ok = 1'b1;
            end
         end
         sle_pkg::REQ_UPDATE: begin
            if (int'(pos) < list_len) begin
               entries[pos] = val;
               r.ok = 1'b1;
            end
         end
         sle_pkg::REQ_REMOVE_AT: begin
            if (int'(pos) < list_len) begin
               drop_entry(int'(pos));
               r.ok = 1'b1;
            end
         end
         sle_pkg::REQ_REMOVE_VALUE: begin
            if (hit >= 0) begin
               drop_entry(hit);
               r.ok = 1'b1;
            end
         end
         sle_pkg::REQ_FIND: begin
            if (hit >= 0) begin
               r.found_position = 4'(hit);
               r.ok = 1'b1;
            end
         end
         sle_pkg::REQ_READ: begin
            if (int'(pos) < list_len) begin
               r.read_value = entries[pos];
               r.ok = 1'b1;
            end else begin
               r.read_value = '1;
            end
         end
         sle_pkg::REQ_COUNT: begin
            for (i = 0; i < list_len; i++) begin
               if (entries[i] == val) r.match_count = r.match_count + 5'd1;
            end
            r.ok = 1'b1;
         end
         sle_pkg::REQ_CLEAR: begin
            list_len = 0;
            r.ok = 1'b1;
         end
         default: ;
      endcase
      r.list_size = 5'(list_len);
      return r;
   endfunction

   task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      list_reply_type want;
      if (reset) begin
         list_len = 0;
         capacity = sle_pkg::CAP_W'(sle_pkg::CAP_RESET);
         replies_due.delete();
      end else begin
         if (csr_valid && csr_ready) capacity = csr_data;
         if (req_tvalid && req_tready) begin
            replies_due.push_back(apply_request(req_tuser, req_tdata[3:0], req_tdata[35:4]));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (replies_due.size() == 0) begin
               $error("response beat with no request outstanding");
               mismatches++;
            end else begin
               want = replies_due.pop_front();
               replies_seen++;
               check_field("ok", 32'(want.ok), 32'(rsp_tdata[0]));
               check_field("read_value", want.read_value, rsp_tdata[32:1]);
               check_field("found_position", 32'(want.found_position), 32'(rsp_tdata[36:33]));
               check_field("match_count", 32'(want.match_count), 32'(rsp_tdata[41:37]));
               check_field("list_size", 32'(want.list_size), 32'(rsp_tdata[46:42]));
            end
         end
      end
      outstanding = replies_due.size();
   end

endmodule

// ===== bench/sequential_list_engine_unit_tb.sv =====
module sequential_list_engine_unit_tb;

   localparam int unsigned LIST_DEPTH = 16;
   localparam int          CYCLE_LIMIT = 400000;
   localparam int          SEGMENTS = 12;
   localparam int          SEGMENT_ITEMS = 129;
   localparam logic [3:0]  REQ_UNKNOWN_LO = 4'd9;
   localparam logic [3:0]  REQ_UNKNOWN_HI = 4'd15;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic [39:0] req_tdata = '0;
   logic [3:0]  req_tuser = '0;
   logic        rsp_tready = 1'b0;
   logic        csr_valid = 1'b0;
   logic [4:0]  csr_data = '0;
   logic        req_tready;
   logic        rsp_tvalid;
   logic [47:0] rsp_tdata;
   logic        csr_ready;

   logic        req_beat = 1'b0;
   logic        csr_beat = 1'b0;
   int          cycles = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          sent = 0;
   int          cap_writes = 0;
   int          fail_count;
   int          pending;
   int          checked;
   logic [4:0]  cap_plan [SEGMENTS];

   sequential_list_engine_unit #(
      .LIST_DEPTH(LIST_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data)
   );

   list_engine_checker #(
      .LIST_DEPTH(LIST_DEPTH)
   ) checker_i (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data),
      .fail_count(fail_count),
      .pending(pending),
      .checked(checked)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      req_beat <= req_tvalid && req_tready;
      csr_beat <= csr_valid && csr_ready;
      cycles   <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_tready <= $urandom_range(99) >= recv_idle_pct;
   end

   task automatic send_req(logic [3:0] code, logic [3:0] pos, logic [31:0] val);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= code;
      req_tdata  <= {val, pos};
      do @(negedge clock); while (!req_beat);
      sent++;
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   task automatic write_capacity(logic [4:0] limit);
      wait_idle();
      csr_valid <= 1'b1;
      csr_data  <= limit;
      do @(negedge clock); while (!csr_beat);
      csr_valid <= 1'b0;
      cap_writes++;
   endtask

   task automatic random_request();
      int          roll;
      logic [3:0]  code;
      logic [3:0]  pos;
      logic [31:0] val;
      roll = $urandom_range(99);
      if (roll < 22) code = sle_pkg::REQ_APPEND;
      else if (roll < 36) code = sle_pkg::REQ_INSERT;
      else if (roll < 46) code = sle_pkg::REQ_UPDATE;
      else if (roll < 58) code = sle_pkg::REQ_REMOVE_AT;
      else if (roll < 68) code = sle_pkg::REQ_REMOVE_VALUE;
      else if (roll < 78) code = sle_pkg::REQ_FIND;
      else if (roll < 88) code = sle_pkg::REQ_READ;
      else if (roll < 94) code = sle_pkg::REQ_COUNT;
      else if (roll < 97) code = sle_pkg::REQ_CLEAR;
      else code = 4'($urandom_range(REQ_UNKNOWN_HI, REQ_UNKNOWN_LO));
      pos = ($urandom_range(2) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(7));
      // small value pool so finds, counts and removes hit often
      case ($urandom_range(7))
         0: val = '0;
         1: val = '1;
         2: val = 32'h7fff_ffff;
         3: val = 32'h8000_0000;
         4: val = 32'($urandom_range(3));
         default: val = $urandom();
      endcase
      send_req(code, pos, val);
   endtask

   initial begin
      cap_plan = '{5'd31, 5'd0, 5'd1, 5'd16, 5'd8, 5'd3, 5'd31, 5'd2, 5'd16, 5'd12, 5'd6, 5'd16};
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      send_idle_pct = 31;
      recv_idle_pct = 53;

      // empty list
      send_req(sle_pkg::REQ_CLEAR, 4'd0, 32'h0);
      send_req(sle_pkg::REQ_READ, 4'd0, 32'h0);
      send_req(sle_pkg::REQ_FIND, 4'd0, 32'h0);
      send_req(sle_pkg::REQ_REMOVE_VALUE, 4'd0, 32'h0);
      send_req(sle_pkg::REQ_REMOVE_AT, 4'd0, 32'h0);
      send_req(sle_pkg::REQ_UPDATE, 4'd0, 32'h1);
      send_req(sle_pkg::REQ_INSERT, 4'd0, 32'h2);
      send_req(sle_pkg::REQ_COUNT, 4'd0, 32'h0);
      // extremes and duplicates
      send_req(sle_pkg::REQ_APPEND, 4'd15, 32'h7fff_ffff);
      send_req(sle_pkg::REQ_APPEND, 4'd0, 32'h8000_0000);
      send_req(sle_pkg::REQ_APPEND, 4'd0, 32'hffff_ffff);
      send_req(sle_pkg::REQ_INSERT, 4'd0, 32'h0);
      send_req(sle_pkg::REQ_INSERT, 4'd2, 32'h8000_0000);
      send_req(sle_pkg::REQ_INSERT, 4'd5, 32'h5);
      send_req(sle_pkg::REQ_UPDATE, 4'd4, 32'h1234_5678);
      send_req(sle_pkg::REQ_FIND, 4'd0, 32'h8000_0000);
      send_req(sle_pkg::REQ_COUNT, 4'd0, 32'h8000_0000);
      send_req(sle_pkg::REQ_READ, 4'd4, 32'h0);
      send_req(sle_pkg::REQ_READ, 4'd15, 32'h0);
      send_req(sle_pkg::REQ_REMOVE_VALUE, 4'd0, 32'h8000_0000);
      send_req(sle_pkg::REQ_REMOVE_AT, 4'd3, 32'h0);
      send_req(sle_pkg::REQ_REMOVE_AT, 4'd0, 32'h0);
      send_req(REQ_UNKNOWN_LO, 4'd3, 32'hdead_beef);
      send_req(REQ_UNKNOWN_HI, 4'd15, 32'hffff_ffff);
      send_req(sle_pkg::REQ_CLEAR, 4'd0, 32'h0);

      for (int seg = 0; seg < SEGMENTS; seg++) begin
         if (seg == 4) begin
            send_idle_pct = 53;
            recv_idle_pct = 31;
         end else if (seg == 8) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         write_capacity(cap_plan[seg]);
         repeat (SEGMENT_ITEMS) random_request();
      end

      wait_idle();
      repeat (LIST_DEPTH + 4) @(negedge clock);
      $display("summary: %0d requests, %0d responses checked, %0d capacity writes (0 to 31)",
               sent, checked, cap_writes);
      if (fail_count == 0 && pending == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
